/* design/crsp_pkg.sv */
// Shared types and constants for the Catmull-Rom spline position block.
// No dependencies.
`timescale 1ns / 1ps
package crsp_pkg;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   localparam int CSR_POINT_COUNT = 0;
   localparam int CSR_LOOP_MODE   = 1;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SEG   = 8'b0000_0010,
      ST_READ  = 8'b0000_0100,
      ST_COEF  = 8'b0000_1000,
      ST_H1    = 8'b0001_0000,
      ST_H2    = 8'b0010_0000,
      ST_H3    = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

endpackage

/* design/crsp_axis.sv */
// One axis of the Horner evaluation: coefficient build and three
// multiply-accumulate steps, one step per cycle. Depends on crsp_pkg.
`timescale 1ns / 1ps
module crsp_axis
   import crsp_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  state_type                   state,
   input  logic                        tap_valid,
   input  logic [1:0]                  tap_index,
   input  logic signed [COORD_BITS-1:0] tap_data,
   input  logic [PARAM_FRAC_BITS:0]    u,
   output logic signed [COORD_BITS-1:0] result
);
   localparam int HB = COORD_BITS + 6;
   localparam int PB = HB + PARAM_FRAC_BITS + 2;

   logic signed [COORD_BITS-1:0] p_ff [4];
   logic signed [HB-1:0] a_ff, b_ff, c_ff, d_ff, h_ff;
   logic signed [HB-1:0] h_in;
   logic signed [PB-1:0] prod;
   logic signed [HB-1:0] addend;
   logic signed [HB-1:0] p0, p1, p2, p3, half;
   logic signed [HB-1:0] hi, lo;

   assign p0 = HB'(p_ff[0]);
   assign p1 = HB'(p_ff[1]);
   assign p2 = HB'(p_ff[2]);
   assign p3 = HB'(p_ff[3]);

   // one Horner step: floor(h*u / 2^F) + next coefficient
   assign prod = PB'(h_ff) * $signed({1'b0, u});
   always_comb begin
      case (state)
         ST_H1:   addend = b_ff;
         ST_H2:   addend = c_ff;
         default: addend = d_ff;
      endcase
      h_in = HB'(prod >>> PARAM_FRAC_BITS) + addend;
   end

   always_ff @(posedge clock) begin
      if (tap_valid) p_ff[tap_index] <= tap_data;
      if (state == ST_COEF) begin
         a_ff <= -p0 + 3 * p1 - 3 * p2 + p3;
         b_ff <= 2 * p0 - 5 * p1 + 4 * p2 - p3;
         c_ff <= p2 - p0;
         d_ff <= 2 * p1;
         h_ff <= -p0 + 3 * p1 - 3 * p2 + p3;
      end else if (state == ST_H1 || state == ST_H2 || state == ST_H3) begin
         h_ff <= h_in;
      end
   end

   // halve and saturate
   assign half = h_ff >>> 1;
   assign hi = HB'({1'b0, {(COORD_BITS-1){1'b1}}});
   assign lo = -hi - HB'(1);
   always_comb begin
      if (half > hi)      result = hi[COORD_BITS-1:0];
      else if (half < lo) result = lo[COORD_BITS-1:0];
      else                result = half[COORD_BITS-1:0];
   end
endmodule

/* design/catmull_rom_spline_position.sv */
// Catmull-Rom spline position unit: point memory, segment search and
// sequencer. Depends on crsp_pkg and crsp_axis.
//
// Usage: a request with req_type = 0 writes one control point into slot
// point_slot (no response). A request with req_type = 1 evaluates the
// spline at position t and returns one response pos_x/y/z.
// A write is stored when it is accepted. An evaluation first finds the
// segment, then reads the four neighbor points from the single-port point
// memory (one per cycle, into a registered read port), then coefficient
// build and three Horner steps share one multiplier per axis. One request
// is in flight at a time; req_ready is low until the response has been
// taken. Writes are accepted every cycle while the block is idle and no
// response is pending.
// The csr_ port sets point_count and loop_mode; the user must write it
// only while idle, which the block itself does not enforce.
// Reset (synchronous) restores point_count = 4 and loop_mode = 0; the
// point memory is not cleared and must be written before it is read.
// When the receiver stalls, the response holds and no request is taken.
`timescale 1ns / 1ps
module catmull_rom_spline_position
   import crsp_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 32,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [5:0]                   req_point_slot,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   input  logic [PARAM_FRAC_BITS:0]     req_position,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_y,
   output logic signed [COORD_BITS-1:0] rsp_pos_z,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [6:0]                   csr_write_data
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = AW + 1;
   localparam int F  = PARAM_FRAC_BITS;
   localparam int SW = F + 1 + NW;

   logic [6:0] point_count_ff;
   logic       loop_mode_ff;
   state_type  state_ff;
   logic [F:0] t_ff, u_ff;
   logic [NW-1:0] n_ff, segs_ff, seg_ff;
   logic [2:0] rd_cnt_ff;
   logic       tap_valid_ff;
   logic [1:0] tap_index_ff;
   logic       rsp_valid_ff;
   logic [COORD_BITS-1:0] ox_ff, oy_ff, oz_ff;

   logic [3*COORD_BITS-1:0] mem [MAX_POINTS];
   logic [3*COORD_BITS-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic signed [NW+1:0] idx_raw;
   logic [NW-1:0] n_clamp;
   logic [SW-1:0] s_full;
   logic [NW-1:0] s_seg, seg_in;
   logic [SW-1:0] u_wide;
   logic signed [COORD_BITS-1:0] rx, ry, rz;
   logic accept;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 7'd4;
         loop_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         if (csr_index == 1'(CSR_POINT_COUNT)) point_count_ff <= csr_write_data;
         else loop_mode_ff <= csr_write_data[0];
      end
   end

   // clamp point count to [4, MAX_POINTS]
   always_comb begin
      if (point_count_ff < 7'd4) n_clamp = NW'(4);
      else if (32'(point_count_ff) > MAX_POINTS) n_clamp = NW'(MAX_POINTS);
      else n_clamp = NW'(point_count_ff);
   end

   // segment search
   assign s_full = SW'(t_ff) * SW'(segs_ff);
   assign s_seg = NW'(s_full >> F);
   assign seg_in = (s_seg > segs_ff - NW'(1)) ? segs_ff - NW'(1) : s_seg;
   assign u_wide = s_full - (SW'(seg_in) << F);

   // neighbor index for the current read
   always_comb begin
      idx_raw = $signed({2'b00, seg_ff}) + $signed({{NW{1'b0}}, rd_cnt_ff[1:0]})
                - (NW+2)'(1);
      if (loop_mode_ff) begin
         if (idx_raw[NW+1]) idx_raw = idx_raw + $signed({2'b00, n_ff});
         else if (idx_raw >= $signed({2'b00, n_ff}))
            idx_raw = idx_raw - $signed({2'b00, n_ff});
      end else begin
         if (idx_raw[NW+1]) idx_raw = '0;
         else if (idx_raw > $signed({2'b00, n_ff}) - (NW+2)'(1))
            idx_raw = $signed({2'b00, n_ff}) - (NW+2)'(1);
      end
      rd_addr = idx_raw[AW-1:0];
   end

   // point memory, single port
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_WRITE && 32'(req_point_slot) < MAX_POINTS)
         mem[AW'(req_point_slot)] <= {req_coord_z, req_coord_y, req_coord_x};
      else
         rd_ff <= mem[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tap_valid_ff <= 1'b0;
         rd_cnt_ff <= '0;
      end else begin
         tap_valid_ff <= (state_ff == ST_READ);
         tap_index_ff <= rd_cnt_ff[1:0];
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept && req_type == REQ_EVAL) begin
               t_ff <= (req_position > (F+1)'(1 << F)) ? (F+1)'(1 << F)
                       : req_position;
               n_ff <= n_clamp;
               segs_ff <= loop_mode_ff ? n_clamp : n_clamp - NW'(1);
               state_ff <= ST_SEG;
            end
            ST_SEG: begin
               seg_ff <= seg_in;
               u_ff <= (u_wide > SW'(1 << F)) ? (F+1)'(1 << F) : u_wide[F:0];
               rd_cnt_ff <= '0;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               rd_cnt_ff <= rd_cnt_ff + 3'd1;
               if (rd_cnt_ff == 3'd3) state_ff <= ST_COEF;
            end
            ST_COEF: if (!tap_valid_ff) state_ff <= ST_H1;
            ST_H1: state_ff <= ST_H2;
            ST_H2: state_ff <= ST_H3;
            ST_H3: state_ff <= ST_OUT;
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT) begin
         ox_ff <= rx;
         oy_ff <= ry;
         oz_ff <= rz;
      end
   end

   crsp_axis #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(F)) u_ax_x (
      .clock, .state(state_ff), .tap_valid(tap_valid_ff), .tap_index(tap_index_ff),
      .tap_data(rd_ff[COORD_BITS-1:0]), .u(u_ff), .result(rx));
   crsp_axis #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(F)) u_ax_y (
      .clock, .state(state_ff), .tap_valid(tap_valid_ff), .tap_index(tap_index_ff),
      .tap_data(rd_ff[2*COORD_BITS-1:COORD_BITS]), .u(u_ff), .result(ry));
   crsp_axis #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(F)) u_ax_z (
      .clock, .state(state_ff), .tap_valid(tap_valid_ff), .tap_index(tap_index_ff),
      .tap_data(rd_ff[3*COORD_BITS-1:2*COORD_BITS]), .u(u_ff), .result(rz));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = ox_ff;
   assign rsp_pos_y = oy_ff;
   assign rsp_pos_z = oz_ff;

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("accept while busy");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT) else $error("stray response");
   a_read_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> rd_cnt_ff < 3'd4) else $error("read overrun");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(ox_ff)) else $error("response moved");
endmodule

/* bench/testbench.sv */
// Self-checking bench for catmull_rom_spline_position: directed rows, then random requests
// checked against a bit-accurate spline predictor. Depends on crsp_pkg and the design.
`timescale 1ns / 1ps
module testbench;
   import crsp_pkg::*;

   localparam int  NUM_SLOTS   = 64;
   localparam int  FRAC        = 16;
   localparam int  ONE_T       = 1 << FRAC;
   localparam int  DRAIN_WAIT  = 20;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  PHASE_ITEMS = 222;

   typedef struct {
      logic               kind;
      logic [5:0]         slot;
      logic signed [31:0] x, y, z;
      logic [16:0]        pos;
   } spline_req_type;

   typedef struct {
      logic signed [31:0] x, y, z;
   } spline_pos_type;

   typedef struct {
      spline_req_type req;
      bit             typed;
      spline_pos_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = REQ_WRITE;
   logic [5:0]         req_point_slot = '0;
   logic signed [31:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic [16:0]        req_position = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = 1'b0;
   logic [6:0]         csr_write_data = '0;

   // predictor state
   logic signed [31:0] shadow_x [NUM_SLOTS];
   logic signed [31:0] shadow_y [NUM_SLOTS];
   logic signed [31:0] shadow_z [NUM_SLOTS];
   int                 shadow_count = 4;
   bit                 shadow_loop = 1'b0;
   spline_pos_type     pending_pos [$];
   int                 errors = 0;
   int                 cycles = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;

   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

   // directed rows; typed expectations only at t = 0 and t >= 1.0 (n = 4, clamped ends)
   stim_row_type directed [12] = '{
      '{'{REQ_WRITE, 6'd0, S_MAX, S_MIN, 32'sd0, 17'd0},        0, '{0, 0, 0}},
      '{'{REQ_WRITE, 6'd1, S_MIN, 32'sd1, -32'sd1, 17'd0},      0, '{0, 0, 0}},
      '{'{REQ_WRITE, 6'd2, S_MAX, S_MIN, 32'sd65536, 17'd0},    0, '{0, 0, 0}},
      '{'{REQ_WRITE, 6'd3, S_MIN, S_MAX, 32'sd12345, 17'd0},    0, '{0, 0, 0}},
      '{'{REQ_EVAL, 6'd0, 0, 0, 0, 17'd0},               1, '{S_MAX, S_MIN, 32'sd0}},
      '{'{REQ_EVAL, 6'd0, 0, 0, 0, 17'd65536},           1, '{S_MIN, S_MAX, 32'sd12345}},
      '{'{REQ_EVAL, 6'd0, 0, 0, 0, 17'h1FFFF},           1, '{S_MIN, S_MAX, 32'sd12345}},
      '{'{REQ_EVAL, 6'd63, 0, 0, 0, 17'd1},              0, '{0, 0, 0}},
      '{'{REQ_EVAL, 6'd0, 0, 0, 0, 17'd21845},           0, '{0, 0, 0}},
      '{'{REQ_EVAL, 6'd0, 0, 0, 0, 17'd32768},           0, '{0, 0, 0}},
      '{'{REQ_EVAL, 6'd0, 0, 0, 0, 17'd65535},           0, '{0, 0, 0}},
      '{'{REQ_WRITE, 6'd63, -32'sd1, S_MAX, S_MIN, 17'd0},      0, '{0, 0, 0}}
   };

   catmull_rom_spline_position DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one axis of the cubic by Horner's rule, floor shifts, saturated
   function automatic logic signed [31:0] spline_axis(longint p0, longint p1, longint p2,
                                                     longint p3, longint u);
      longint a, b, c, d, h;
      a = -p0 + 3 * p1 - 3 * p2 + p3;
      b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c = p2 - p0;
      d = 2 * p1;
      h = ((a * u) >>> FRAC) + b;
      h = ((h * u) >>> FRAC) + c;
      h = ((h * u) >>> FRAC) + d;
      h = h >>> 1;
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      return h[31:0];
   endfunction

   function automatic spline_pos_type predict_position(logic [16:0] position);
      int             n, segs, seg, i;
      longint         t, s, u;
      int             idx [4];
      spline_pos_type r;
      n = shadow_count < 4 ? 4 : (shadow_count > NUM_SLOTS ? NUM_SLOTS : shadow_count);
      segs = shadow_loop ? n : n - 1;
      t = position > ONE_T ? ONE_T : position;
      s = t * segs;
      seg = int'(s >> FRAC);
      if (seg > segs - 1) seg = segs - 1;
      u = s - (longint'(seg) << FRAC);
      if (u > ONE_T) u = ONE_T;
      for (int k = 0; k < 4; k++) begin
         i = seg + k - 1;
         if (shadow_loop) idx[k] = (i + n) % n;
         else idx[k] = i < 0 ? 0 : (i > n - 1 ? n - 1 : i);
      end
      r.x = spline_axis(shadow_x[idx[0]], shadow_x[idx[1]], shadow_x[idx[2]],
                        shadow_x[idx[3]], u);
      r.y = spline_axis(shadow_y[idx[0]], shadow_y[idx[1]], shadow_y[idx[2]],
                        shadow_y[idx[3]], u);
      r.z = spline_axis(shadow_z[idx[0]], shadow_z[idx[1]], shadow_z[idx[2]],
                        shadow_z[idx[3]], u);
      return r;
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(7))
         0: return S_MAX;
         1: return S_MIN;
         2: return 32'($signed($urandom_range(131072)) - 65536);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] rand_position();
      case ($urandom_range(9))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   // drive one request, hold until taken, then update the predictor
   task automatic send_request(spline_req_type r, bit typed, spline_pos_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= r.kind;
      req_point_slot <= r.slot;
      req_coord_x    <= r.x;
      req_coord_y    <= r.y;
      req_coord_z    <= r.z;
      req_position   <= r.pos;
      do @(posedge clock); while (!req_ready);
      if (r.kind == REQ_WRITE) begin
         shadow_x[r.slot] = r.x;
         shadow_y[r.slot] = r.y;
         shadow_z[r.slot] = r.z;
      end else begin
         pending_pos.push_back(typed ? want : predict_position(r.pos));
      end
   endtask

   // wait for the block to go idle, then program both registers
   task automatic set_config(int count, bit loop_on);
      req_valid <= 1'b0;
      while (pending_pos.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= 1'(CSR_POINT_COUNT);
      csr_write_data   <= 7'(count);
      @(posedge clock);
      csr_index        <= 1'(CSR_LOOP_MODE);
      csr_write_data   <= 7'(loop_on);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_count = count;
      shadow_loop  = loop_on;
   endtask

   // response check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pos.size() == 0) begin
            $display("%0t unexpected response x=%0d y=%0d z=%0d", $time,
                     rsp_pos_x, rsp_pos_y, rsp_pos_z);
            errors++;
         end else begin
            spline_pos_type e;
            e = pending_pos.pop_front();
            if (rsp_pos_x !== e.x) begin
               $display("%0t pos_x expected %0d actual %0d", $time, e.x, rsp_pos_x);
               errors++;
            end
            if (rsp_pos_y !== e.y) begin
               $display("%0t pos_y expected %0d actual %0d", $time, e.y, rsp_pos_y);
               errors++;
            end
            if (rsp_pos_z !== e.z) begin
               $display("%0t pos_z expected %0d actual %0d", $time, e.z, rsp_pos_z);
               errors++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int             counts [8] = '{4, 64, 0, 127, 17, 5, 64, 3};
      bit             loops  [8] = '{1, 1, 0, 0, 1, 0, 0, 1};
      spline_req_type r;
      spline_pos_type none;
      none = '{0, 0, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every slot so no evaluation reads an unwritten point
      for (int s = 0; s < NUM_SLOTS; s++) begin
         r = '{REQ_WRITE, 6'(s), rand_coord(), rand_coord(), rand_coord(), 17'($urandom)};
         send_request(r, 0, none);
      end
      foreach (directed[i]) send_request(directed[i].req, directed[i].typed,
                                         directed[i].want);

      // random phases over several register settings and idle patterns
      for (int ph = 0; ph < 8; ph++) begin
         set_config(counts[ph], loops[ph]);
         if (ph < 3) begin
            send_idle_pct = 8;
            recv_idle_pct = 66;
         end else if (ph < 6) begin
            send_idle_pct = 66;
            recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r.kind = ($urandom_range(99) < 30) ? REQ_WRITE : REQ_EVAL;
            r.slot = 6'($urandom);
            r.x    = rand_coord();
            r.y    = rand_coord();
            r.z    = rand_coord();
            r.pos  = rand_position();
            send_request(r, 0, none);
         end
      end
      req_valid <= 1'b0;

      while (pending_pos.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
